FILE: rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and codes for the compacting list table
// Command and status codes, the controller state type and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Request command codes.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_FULL         = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_WAIT,
    S_SCAN,
    S_SHIFT
  } state_t;

  // Source of the memory read address.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_INDEX,
    RD_PTR_NEXT
  } rd_sel_t;

  // Source of the memory write address and data.
  typedef enum logic {
    WR_APPEND,
    WR_SHIFT
  } wr_sel_t;

  // Source of the result word.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_VALUE
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_in;
    logic       mem_re;
    rd_sel_t    rd_sel;
    logic       mem_we;
    wr_sel_t    wr_sel;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       load_out;
    res_sel_t   res_sel;
    logic [1:0] res_status;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       idx_oor;
    logic       cnt_zero;
    logic       match;
    logic       last;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/clt_datapath.sv
// ----------------------------------------------------------------------------
// clt_datapath: storage and arithmetic of the compacting list table
// Holds the entry memory, the fill count, the scan pointer, the captured
// request and the output register, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module clt_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_command,
  input  logic signed [31:0]  in_value,
  input  logic [3:0]          in_index,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_read_value,
  output logic [1:0]          out_status,
  output logic [4:0]          out_entry_count,
  input  clt_pkg::ctl_t       ctl,
  output clt_pkg::sts_t       sts
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XW  = (CW > 4) ? CW : 4;
  localparam int EXW = (CW > 5) ? CW : 5;

  logic signed [31:0] mem [DEPTH];

  logic [1:0]         cmd_r;
  logic signed [31:0] value_r;
  logic [3:0]         index_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [AW-1:0]      ptr_r;
  logic signed [31:0] rdata_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;
  logic [4:0]         out_count_r;

  logic [CW-1:0]      ptr_next_c;
  logic [XW-1:0]      idx_x;
  logic [XW-1:0]      cnt_x;
  logic [EXW-1:0]     cnt_out_x;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic signed [31:0] res_value;

  // Captured request.
  always_ff @(posedge clk) begin
    if (ctl.cap_in) begin
      cmd_r   <= in_command;
      value_r <= in_value;
      index_r <= in_index;
    end
  end

  // Fill count.
  assign count_nxt = count_r + CW'(ctl.cnt_inc) - CW'(ctl.cnt_dec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Scan and shift pointer.
  always_ff @(posedge clk) begin
    if (ctl.ptr_clr) begin
      ptr_r <= '0;
    end else if (ctl.ptr_inc) begin
      ptr_r <= ptr_r + AW'(1);
    end
  end

  assign ptr_next_c = CW'(ptr_r) + CW'(1);

  // Address and data selection.
  assign idx_x = XW'(index_r);
  assign cnt_x = XW'(count_r);

  always_comb begin
    unique case (ctl.rd_sel)
      clt_pkg::RD_ZERO:     raddr = '0;
      clt_pkg::RD_INDEX:    raddr = AW'(idx_x);
      clt_pkg::RD_PTR_NEXT: raddr = AW'(ptr_next_c);
      default:              raddr = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.wr_sel)
      clt_pkg::WR_APPEND: begin
        waddr = AW'(count_r);
        wdata = value_r;
      end
      clt_pkg::WR_SHIFT: begin
        waddr = ptr_r - AW'(1);
        wdata = rdata_r;
      end
      default: begin
        waddr = '0;
        wdata = value_r;
      end
    endcase
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Result word selection.
  always_comb begin
    unique case (ctl.res_sel)
      clt_pkg::RES_ZERO:  res_value = '0;
      clt_pkg::RES_RDATA: res_value = rdata_r;
      clt_pkg::RES_VALUE: res_value = value_r;
      default:            res_value = '0;
    endcase
  end

  assign cnt_out_x = EXW'(count_nxt);

  // Output register; the request count leaves with the updated fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_value_r  <= res_value;
      out_status_r <= ctl.res_status;
      out_count_r  <= cnt_out_x[4:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  // Status toward the controller.
  assign sts.cmd      = cmd_r;
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.idx_oor  = (idx_x >= cnt_x);
  assign sts.cnt_zero = (count_r == '0);
  assign sts.match    = (rdata_r == value_r);
  assign sts.last     = (ptr_next_c >= count_r);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

FILE: rtl/clt_ctrl.sv
// ----------------------------------------------------------------------------
// clt_ctrl: sequencer of the compacting list table
// Takes one request at a time, walks the entries for a remove, closes the gap
// one entry per cycle and loads the result when the output register is free.
// ----------------------------------------------------------------------------
module clt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  clt_pkg::sts_t  sts,
  output clt_pkg::ctl_t  ctl
);

  clt_pkg::state_t state_r;
  clt_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    ctl            = '0;
    ctl.rd_sel     = clt_pkg::RD_ZERO;
    ctl.wr_sel     = clt_pkg::WR_APPEND;
    ctl.res_sel    = clt_pkg::RES_ZERO;
    ctl.res_status = clt_pkg::ST_OK;

    unique case (state_r)
      clt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cap_in = 1'b1;
          state_nxt  = clt_pkg::S_DISPATCH;
        end
      end

      clt_pkg::S_DISPATCH: begin
        unique case (sts.cmd)
          clt_pkg::CMD_APPEND: begin
            if (sts.out_free) begin
              ctl.load_out = 1'b1;
              if (sts.full) begin
                ctl.res_status = clt_pkg::ST_FULL;
              end else begin
                ctl.mem_we  = 1'b1;
                ctl.wr_sel  = clt_pkg::WR_APPEND;
                ctl.cnt_inc = 1'b1;
              end
              state_nxt = clt_pkg::S_IDLE;
            end
          end
          clt_pkg::CMD_REMOVE: begin
            if (sts.cnt_zero) begin
              if (sts.out_free) begin
                ctl.load_out   = 1'b1;
                ctl.res_status = clt_pkg::ST_NOT_FOUND;
                state_nxt      = clt_pkg::S_IDLE;
              end
            end else begin
              ctl.mem_re  = 1'b1;
              ctl.rd_sel  = clt_pkg::RD_ZERO;
              ctl.ptr_clr = 1'b1;
              state_nxt   = clt_pkg::S_SCAN;
            end
          end
          clt_pkg::CMD_READ: begin
            if (sts.idx_oor) begin
              if (sts.out_free) begin
                ctl.load_out   = 1'b1;
                ctl.res_status = clt_pkg::ST_OUT_OF_RANGE;
                state_nxt      = clt_pkg::S_IDLE;
              end
            end else begin
              ctl.mem_re = 1'b1;
              ctl.rd_sel = clt_pkg::RD_INDEX;
              state_nxt  = clt_pkg::S_READ_WAIT;
            end
          end
          default: begin
            // Unused command code: report the count and change nothing.
            if (sts.out_free) begin
              ctl.load_out = 1'b1;
              state_nxt    = clt_pkg::S_IDLE;
            end
          end
        endcase
      end

      clt_pkg::S_READ_WAIT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          ctl.res_sel  = clt_pkg::RES_RDATA;
          state_nxt    = clt_pkg::S_IDLE;
        end
      end

      clt_pkg::S_SCAN: begin
        // The read data holds the entry at the pointer; fetch the next one
        // while comparing so the walk covers one entry per cycle.
        if (!sts.last) begin
          ctl.mem_re  = 1'b1;
          ctl.rd_sel  = clt_pkg::RD_PTR_NEXT;
          ctl.ptr_inc = 1'b1;
          if (sts.match) begin
            state_nxt = clt_pkg::S_SHIFT;
          end
        end else if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = clt_pkg::S_IDLE;
          if (sts.match) begin
            ctl.cnt_dec = 1'b1;
            ctl.res_sel = clt_pkg::RES_VALUE;
          end else begin
            ctl.res_status = clt_pkg::ST_NOT_FOUND;
          end
        end
      end

      clt_pkg::S_SHIFT: begin
        // Move the entry at the pointer down by one place.
        if (!sts.last) begin
          ctl.mem_we  = 1'b1;
          ctl.wr_sel  = clt_pkg::WR_SHIFT;
          ctl.mem_re  = 1'b1;
          ctl.rd_sel  = clt_pkg::RD_PTR_NEXT;
          ctl.ptr_inc = 1'b1;
        end else if (sts.out_free) begin
          ctl.mem_we   = 1'b1;
          ctl.wr_sel   = clt_pkg::WR_SHIFT;
          ctl.cnt_dec  = 1'b1;
          ctl.load_out = 1'b1;
          ctl.res_sel  = clt_pkg::RES_VALUE;
          state_nxt    = clt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = clt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/compacting_list_table_top.sv
// ----------------------------------------------------------------------------
// compacting_list_table_top: ordered list of up to DEPTH words
// Append, remove-first-match and read-at-index on a list held in one memory.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with one result.
// Append, an unused command code and any failing read or append load their
// result from the dispatch state; a read loads it from the read-wait state.
// A remove walks the memory through its single registered read port at one
// entry per cycle and then closes the gap at one entry per cycle, so it
// passes over all N entries, where N is the fill count, whatever position
// matches. A new request is accepted as soon as the sequencer returns to
// idle, even while the previous result still waits in the output register;
// a result waits in the sequencer only while that register is still
// occupied. The entries need no clearing after reset.
module compacting_list_table_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_value,
  input  logic [3:0]         in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_read_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count
);

  clt_pkg::ctl_t ctl;
  clt_pkg::sts_t sts;

  // Sequencer.
  clt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Storage and output register.
  clt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .ctl             (ctl),
    .sts             (sts)
  );

  // The count never moves both ways in one cycle.
  a_cnt_one_way: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.cnt_inc && ctl.cnt_dec))
    else $error("fill count incremented and decremented together");

  // An append writes the memory only when there is room.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mem_we && ctl.wr_sel == clt_pkg::WR_APPEND) |-> !sts.full)
    else $error("append written into a full list");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> sts.out_free)
    else $error("result overwrote a pending result");

  // After a request is accepted the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while busy");

endmodule
